// ----- src/smt_pkg.sv -----
// ----------------------------------------------------------------------------
// smt_pkg: shared types and constants of the set membership table
// Item and result layouts, command bundle for the cell row, status codes.
// ----------------------------------------------------------------------------
package smt_pkg;

  localparam int unsigned DefDepth = 16;
  localparam int unsigned ValueW   = 32;
  localparam int unsigned CountW   = 5;

  typedef logic [1:0] func_t;

  localparam func_t FuncInsert = 2'd0;
  localparam func_t FuncRemove = 2'd1;
  localparam func_t FuncQuery  = 2'd2;

  typedef enum logic [1:0] {
    StatusOk      = 2'd0,
    StatusFull    = 2'd1,
    StatusPresent = 2'd2,
    StatusAbsent  = 2'd3
  } status_e;

  typedef struct packed {
    func_t              func;
    logic [ValueW-1:0]  value;
  } smt_req_t;

  typedef struct packed {
    status_e            status;
    logic               found;
    logic [CountW-1:0]  count;
  } smt_rsp_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic               cmp;
    logic               ins;
    logic               rem;
    logic [ValueW-1:0]  value;
  } smt_cmd_t;

endpackage

// ----- src/smt_cell.sv -----
// ----------------------------------------------------------------------------
// smt_cell: one slot of the set
// Holds one value, registers its own compare hit and shifts down on remove.
// ----------------------------------------------------------------------------
module smt_cell import smt_pkg::*; #(
  parameter int unsigned DEPTH = DefDepth,
  parameter int unsigned IDX   = 0
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  smt_cmd_t                       cmd_i,
  input  logic [$clog2(DEPTH+1)-1:0]     count_i,
  input  logic [ValueW-1:0]              next_entry_i,
  input  logic                           passed_i,
  output logic [ValueW-1:0]              entry_o,
  output logic                           passed_o,
  output logic                           hit_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [ValueW-1:0] entry_q;
  logic              hit_q, hit_d;
  logic              occupied;
  logic              is_tail;

  assign occupied = CntW'(IDX) < count_i;
  assign is_tail  = CntW'(IDX) == count_i;
  assign hit_d    = cmd_i.cmp && occupied && (entry_q == cmd_i.value);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= hit_d;
    end
  end

  // Append at the tail slot; on remove, slots at or above the hit pull from above.
  always_ff @(posedge clk_i) begin
    if (cmd_i.ins && is_tail) begin
      entry_q <= cmd_i.value;
    end else if (cmd_i.rem && passed_o) begin
      entry_q <= next_entry_i;
    end
  end

  assign passed_o = passed_i | hit_q;
  assign hit_o    = hit_q;
  assign entry_o  = entry_q;

endmodule

// ----- src/smt_ctrl.sv -----
// ----------------------------------------------------------------------------
// smt_ctrl: sequencer, count and result register
// Steps each item through compare and update, then emits the result.
// ----------------------------------------------------------------------------
module smt_ctrl import smt_pkg::*; #(
  parameter int unsigned DEPTH = DefDepth
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  smt_req_t                       req_i,
  input  logic                           any_hit_i,
  output smt_cmd_t                       cmd_o,
  output logic [$clog2(DEPTH+1)-1:0]     count_o,
  output logic                           done_o,
  output smt_rsp_t                       rsp_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StCmp  = 3'b010,
    StUpd  = 3'b100
  } state_e;

  state_e            state_q, state_d;
  func_t             func_q;
  logic [ValueW-1:0] value_q;
  logic [CntW-1:0]   count_q, count_d;
  logic              done_q;
  smt_rsp_t          rsp_q, rsp_d;
  logic              full;
  logic              do_ins, do_rem;
  status_e           status;
  logic [CntW+CountW-1:0] count_ext;

  assign full   = count_q >= CntW'(DEPTH);
  assign do_ins = (state_q == StUpd) && (func_q == FuncInsert) && !any_hit_i && !full;
  assign do_rem = (state_q == StUpd) && (func_q == FuncRemove) && any_hit_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (start_i) state_d = StCmp;
      StCmp:   state_d = StUpd;
      StUpd:   state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (do_ins) begin
      count_d = count_q + CntW'(1);
    end else if (do_rem) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_comb begin
    if (func_q == FuncInsert) begin
      if (any_hit_i)  status = StatusPresent;
      else if (full)  status = StatusFull;
      else            status = StatusOk;
    end else begin
      status = any_hit_i ? StatusOk : StatusAbsent;
    end
  end

  assign count_ext    = {{CountW{1'b0}}, count_d};
  assign rsp_d.status = status;
  assign rsp_d.found  = any_hit_i;
  assign rsp_d.count  = count_ext[CountW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= (state_q == StUpd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && start_i) begin
      func_q  <= req_i.func;
      value_q <= req_i.value;
    end
    if (state_q == StUpd) begin
      rsp_q <= rsp_d;
    end
  end

  assign cmd_o.cmp   = (state_q == StCmp);
  assign cmd_o.ins   = do_ins;
  assign cmd_o.rem   = do_rem;
  assign cmd_o.value = value_q;

  assign busy_o  = (state_q != StIdle);
  assign count_o = count_q;
  assign done_o  = done_q;
  assign rsp_o   = rsp_q;

endmodule

// ----- src/set_membership_table_top.sv -----
// The result strobe is registered: it rises after the item passes the compare and update steps.
// Items are taken one at a time: busy_o stays high through the sequencer's compare step
//   (each cell registers its own hit) and the update step that follows.
// Reset clears the count and the sequencer; stored values stay undefined and are
//   never read until written. The receiver cannot stall: each result strobe shows for one cycle.
// ----------------------------------------------------------------------------
// set_membership_table_top: packed set of distinct values with delete
// A row of cells, one per slot, compares the item's value in parallel; a hit
// ripples up the row so the hit slot and every slot above it pull from their
// neighbor above, closing the gap in the update step.
// ----------------------------------------------------------------------------
module set_membership_table_top import smt_pkg::*; #(
  parameter int unsigned DEPTH = DefDepth
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  output logic     busy_o,
  input  smt_req_t req_i,
  output logic     done_o,
  output smt_rsp_t rsp_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  smt_cmd_t          cmd;
  logic [CntW-1:0]   count;
  logic [ValueW-1:0] entry_w [DEPTH];
  logic [DEPTH:0]    passed_w;
  logic [DEPTH-1:0]  hit_w;

  // Nothing precedes the bottom slot; the top of the chain says whether any slot hit.
  assign passed_w[0] = 1'b0;

  smt_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .busy_o    (busy_o),
    .req_i     (req_i),
    .any_hit_i (passed_w[DEPTH]),
    .cmd_o     (cmd),
    .count_o   (count),
    .done_o    (done_o),
    .rsp_o     (rsp_o)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ValueW-1:0] next_entry;

    // The top slot has no neighbor above; hold its own value on a shift.
    if (i == DEPTH - 1) begin : g_top
      assign next_entry = entry_w[i];
    end else begin : g_mid
      assign next_entry = entry_w[i+1];
    end

    smt_cell #(
      .DEPTH(DEPTH),
      .IDX  (i)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .count_i      (count),
      .next_entry_i (next_entry),
      .passed_i     (passed_w[i]),
      .entry_o      (entry_w[i]),
      .passed_o     (passed_w[i+1]),
      .hit_o        (hit_w[i])
    );
  end

  // Values are kept distinct, so at most one slot may match.
  a_single_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(hit_w))
    else $error("more than one slot matched");

  // Count never goes past the slot row.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= CntW'(DEPTH))
    else $error("count exceeds depth");

  // An accepted item gives its result strobe after the compare and update steps.
  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##3 done_o)
    else $error("result strobe missing");

  // Only an insert or remove moves the count, and by one.
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(count) |-> $past(cmd.ins) || $past(cmd.rem))
    else $error("count changed without an update");

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the set membership table
// Sends insert, remove and query commands with random gaps and compares every
// result strobe, field by field, against a shadow copy of the packed set or a hand-typed row.
// ----------------------------------------------------------------------------
module tb_top;
  import smt_pkg::*;

  localparam int unsigned Depth      = DefDepth;
  localparam int unsigned RandItems  = 1700;
  localparam int unsigned PoolSize   = 20;     // a few more values than slots
  localparam int unsigned WatchLimit = 1000;   // well above the longest random gap
  localparam int unsigned DrainWait  = 8;

  // The fourth selector code is unused by the block; it must act as a query.
  localparam func_t FuncSpare = 2'd3;

  typedef struct {
    smt_req_t req;
    bit       typed;   // expected result written into the row by hand
    smt_rsp_t rsp;
  } dir_row_t;

  logic     clk_i   = 1'b0;
  logic     rst_ni  = 1'b0;
  logic     start_i = 1'b0;
  smt_req_t req_i   = '0;
  logic     busy_o;
  logic     done_o;
  smt_rsp_t rsp_o;

  // Shadow of the set: packed values below held_count, as in the block.
  logic [ValueW-1:0] held_vals [Depth];
  int unsigned       held_count;

  smt_rsp_t    pending_rsp [$];
  smt_rsp_t    due_rsp;
  dir_row_t    dir_rows [$];
  int unsigned mismatch_count;
  int unsigned results_seen;
  int unsigned idle_cycles;
  bit          gap_mode;

  set_membership_table_top #(
    .DEPTH (Depth)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Apply one command to the shadow set and return the result it must give.
  function automatic smt_rsp_t set_apply(smt_req_t cmd);
    smt_rsp_t rsp;
    int       slot;
    slot = -1;
    for (int i = 0; i < int'(held_count); i++) begin
      if (slot < 0 && held_vals[i] == cmd.value) slot = i;
    end
    rsp.found = (slot >= 0);
    case (cmd.func)
      FuncInsert: begin
        if (slot >= 0) begin
          rsp.status = StatusPresent;        // duplicate wins over full
        end else if (held_count >= Depth) begin
          rsp.status = StatusFull;
        end else begin
          held_vals[held_count] = cmd.value;
          held_count++;
          rsp.status = StatusOk;
        end
      end
      FuncRemove: begin
        if (slot >= 0) begin
          // close the gap: every later entry moves down one slot
          for (int i = slot; i + 1 < int'(held_count); i++) held_vals[i] = held_vals[i + 1];
          held_count--;
          rsp.status = StatusOk;
        end else begin
          rsp.status = StatusAbsent;
        end
      end
      default: begin
        rsp.status = (slot >= 0) ? StatusOk : StatusAbsent;
      end
    endcase
    rsp.count = CountW'(held_count);
    return rsp;
  endfunction

  function automatic dir_row_t mk_row(func_t f, logic [ValueW-1:0] v, bit typed,
                                      status_e st, logic fnd, int unsigned cnt);
    dir_row_t row;
    row.req.func   = f;
    row.req.value  = v;
    row.typed      = typed;
    row.rsp.status = st;
    row.rsp.found  = fnd;
    row.rsp.count  = CountW'(cnt);
    return row;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 40) $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Hold the command until the block takes it, record what it must answer,
  // then either keep start high for the next item or drop it for a gap.
  task automatic send_item(input smt_req_t cmd, input bit typed, input smt_rsp_t typed_rsp);
    smt_rsp_t    pred;
    int unsigned gap;
    start_i <= 1'b1;
    req_i   <= cmd;
    do @(posedge clk_i); while (busy_o);
    pred = set_apply(cmd);
    pending_rsp.push_back(typed ? typed_rsp : pred);
    if (gap_mode && $urandom_range(0, 2) == 0) begin
      // mostly short gaps that land on each step of the block's sequence,
      // now and then a long one
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 4);
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Result checker: every strobe must match the oldest waiting expectation.
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      if (pending_rsp.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with no item waiting", results_seen));
      end else begin
        due_rsp = pending_rsp.pop_front();
        if (rsp_o.status !== due_rsp.status)
          report_mismatch($sformatf("result %0d status %0d, want %0d",
                                    results_seen, rsp_o.status, due_rsp.status));
        if (rsp_o.found !== due_rsp.found)
          report_mismatch($sformatf("result %0d found %0b, want %0b",
                                    results_seen, rsp_o.found, due_rsp.found));
        if (rsp_o.count !== due_rsp.count)
          report_mismatch($sformatf("result %0d count %0d, want %0d",
                                    results_seen, rsp_o.count, due_rsp.count));
      end
      results_seen++;
    end
  end

  // Watchdog: end the run if neither an item nor a result moves for too long.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o === 1'b1) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    logic [ValueW-1:0] pool [PoolSize];
    smt_req_t          cmd;
    int unsigned       roll;
    int unsigned       ins_pct;
    held_count     = 0;
    mismatch_count = 0;
    results_seen   = 0;
    idle_cycles    = 0;
    gap_mode       = 1'b0;
    ins_pct        = 50;

    // Directed rows. Typed expectations only where the answer is obvious:
    // the empty table, duplicates, the full table and the unused selector.
    dir_rows.push_back(mk_row(FuncQuery,  32'h0000_0000, 1, StatusAbsent,  0, 0));
    dir_rows.push_back(mk_row(FuncRemove, 32'hFFFF_FFFF, 1, StatusAbsent,  0, 0));
    dir_rows.push_back(mk_row(FuncInsert, 32'h0000_0000, 1, StatusOk,      0, 1));
    dir_rows.push_back(mk_row(FuncInsert, 32'h0000_0000, 1, StatusPresent, 1, 1));
    dir_rows.push_back(mk_row(FuncInsert, 32'hFFFF_FFFF, 1, StatusOk,      0, 2));
    dir_rows.push_back(mk_row(FuncQuery,  32'hFFFF_FFFF, 1, StatusOk,      1, 2));
    dir_rows.push_back(mk_row(FuncSpare,  32'hFFFF_FFFF, 1, StatusOk,      1, 2));
    // fill the remaining slots with walking ones
    for (int i = 0; i < int'(Depth) - 2; i++)
      dir_rows.push_back(mk_row(FuncInsert, 32'h1 << i, 0, StatusOk, 0, 0));
    dir_rows.push_back(mk_row(FuncInsert, 32'h8000_0000, 1, StatusFull,    0, Depth));
    dir_rows.push_back(mk_row(FuncInsert, 32'hFFFF_FFFF, 1, StatusPresent, 1, Depth));
    dir_rows.push_back(mk_row(FuncRemove, 32'h0000_0020, 0, StatusOk,      0, 0));
    dir_rows.push_back(mk_row(FuncRemove, 32'h0000_0000, 0, StatusOk,      0, 0));

    // Hold reset, then release it once for the whole run.
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_item(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);

    // Random part: values mostly from a small pool so hits, duplicates and
    // removes in the middle are common; the insert bias drifts so the table
    // swings between empty and full.
    for (int n = 0; n < int'(RandItems); n++) begin
      if (n % 200 == 0) begin
        foreach (pool[k]) pool[k] = $urandom();
      end
      if (n % 150 == 0) gap_mode = ($urandom_range(0, 2) != 0);
      if (n % 120 == 0) ins_pct = $urandom_range(15, 85);
      roll = $urandom_range(0, 99);
      if (roll < 5)       cmd.func = FuncSpare;
      else if (roll < 30) cmd.func = FuncQuery;
      else                cmd.func = ($urandom_range(0, 99) < ins_pct) ? FuncInsert : FuncRemove;
      cmd.value = ($urandom_range(0, 9) < 8) ? pool[$urandom_range(0, PoolSize - 1)]
                                             : $urandom();
      send_item(cmd, 1'b0, '0);
    end
    start_i <= 1'b0;

    // Drain: wait for every outstanding result, then watch for strays.
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
